/* rtl/core/mvgif_pkg.sv */
// Shared widths, defaults and controller/datapath handshake types for the gain index fader.
`default_nettype none

package mvgif_pkg;

    localparam int NUM_VOICES_DEF = 8;

    localparam int KIND_W  = 2;
    localparam int VOICE_W = 3;
    localparam int IDX_W   = 8;
    localparam int MS_W    = 16;
    localparam int FRAC_W  = 16;

    // dividend is (diff * 3) << 16: 8-bit diff times 3 fits in 10 bits
    localparam int DVD_W = IDX_W + 2 + FRAC_W;
    localparam int QUO_W = 24;

    typedef struct packed {
        logic load;       // latch the incoming request
        logic start_div;  // launch the step division
        logic commit;     // write voice state and load the result register
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/multi_voice_gain_index_fader.sv */
// Ticks, stops, sets and short fades go from accept via the check state to the commit; the
// start of a fade of 3 ms or more to a new index also waits for the bit-serial step divider
// (26 steps). A request is accepted only after the last one is committed; a waiting result
// does not block the next accept, only the following commit.
// Reset (synchronous, active low) clears all voice state, the controller and the result valid.
`default_nettype none

module multi_voice_gain_index_fader #(
    parameter int NUM_VOICES = mvgif_pkg::NUM_VOICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [mvgif_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [mvgif_pkg::VOICE_W-1:0]   i_voice,
    input  wire logic [mvgif_pkg::IDX_W-1:0]     i_target_index,
    input  wire logic [mvgif_pkg::MS_W-1:0]      i_fade_ms,
    input  wire logic                            i_stop_at_end,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [mvgif_pkg::VOICE_W-1:0]        o_voice_out,
    output logic [mvgif_pkg::IDX_W-1:0]          o_gain_index,
    output logic                                 o_fading,
    output logic                                 o_stop_now
);

    mvgif_pkg::t_cmd w_cmd;
    mvgif_pkg::t_sts w_sts;

    mvgif_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    mvgif_dp #(
        .NUM_VOICES (NUM_VOICES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_voice        (i_voice),
        .i_target_index (i_target_index),
        .i_fade_ms      (i_fade_ms),
        .i_stop_at_end  (i_stop_at_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_voice_out    (o_voice_out),
        .o_gain_index   (o_gain_index),
        .o_fading       (o_fading),
        .o_stop_now     (o_stop_now)
    );

endmodule

`default_nettype wire

/* rtl/core/mvgif_div.sv */
// Restoring divider, one quotient bit per cycle, for the fade step.
`default_nettype none

module mvgif_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mvgif_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [mvgif_pkg::MS_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [mvgif_pkg::QUO_W-1:0]        o_quotient
);

    localparam int CNT_W = $clog2(mvgif_pkg::DVD_W + 1);

    logic [mvgif_pkg::DVD_W-1:0] r_dvd;
    logic [mvgif_pkg::MS_W-1:0]  r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [mvgif_pkg::MS_W:0]    w_trial;
    logic                        w_fits;
    logic [mvgif_pkg::MS_W:0]    w_diff;

    assign w_trial = {r_rem, r_dvd[mvgif_pkg::DVD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(mvgif_pkg::DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend register shifts left and collects quotient bits at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[mvgif_pkg::DVD_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[mvgif_pkg::MS_W-1:0] : w_trial[mvgif_pkg::MS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd[mvgif_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/mvgif_dp.sv */
// Datapath: request latch, per-voice fader state, update logic, divider and result register.
`default_nettype none

module mvgif_dp #(
    parameter int NUM_VOICES = mvgif_pkg::NUM_VOICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mvgif_pkg::t_cmd                 i_cmd,
    output mvgif_pkg::t_sts                      o_sts,
    input  wire logic [mvgif_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [mvgif_pkg::VOICE_W-1:0]   i_voice,
    input  wire logic [mvgif_pkg::IDX_W-1:0]     i_target_index,
    input  wire logic [mvgif_pkg::MS_W-1:0]      i_fade_ms,
    input  wire logic                            i_stop_at_end,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [mvgif_pkg::VOICE_W-1:0]        o_voice_out,
    output logic [mvgif_pkg::IDX_W-1:0]          o_gain_index,
    output logic                                 o_fading,
    output logic                                 o_stop_now
);

    localparam int VW     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int IDX_W  = mvgif_pkg::IDX_W;
    localparam int FRAC_W = mvgif_pkg::FRAC_W;
    localparam int ACC_W  = 32;
    localparam int STEP_W = mvgif_pkg::QUO_W;
    localparam int SHORT_MS = 3;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_SET   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SPH_NONE   = 2'd0,
        SPH_JUMP   = 2'd1,
        SPH_FINISH = 2'd2
    } t_sph;

    // latched request
    logic [mvgif_pkg::KIND_W-1:0]  r_kind;
    logic [mvgif_pkg::VOICE_W-1:0] r_voice;
    logic [IDX_W-1:0]              r_targ;
    logic [mvgif_pkg::MS_W-1:0]    r_ms;
    logic                          r_stop;

    // per-voice state
    logic [IDX_W-1:0]  r_cur [NUM_VOICES];
    logic [IDX_W-1:0]  r_tgt [NUM_VOICES];
    logic [ACC_W-1:0]  r_acc [NUM_VOICES];
    logic [STEP_W-1:0] r_stp [NUM_VOICES];
    logic              r_up  [NUM_VOICES];
    logic              r_on  [NUM_VOICES];
    logic              r_stf [NUM_VOICES];
    t_sph              r_sph [NUM_VOICES];

    // result register
    logic                          r_out_valid;
    logic [mvgif_pkg::VOICE_W-1:0] r_out_voice;
    logic [IDX_W-1:0]              r_out_gain;
    logic                          r_out_fading;
    logic                          r_out_stop;

    logic [VW-1:0]     w_vidx;
    logic              w_voice_ok;
    logic [IDX_W-1:0]  w_cur;
    logic [IDX_W-1:0]  w_tgt;
    logic [ACC_W-1:0]  w_acc;
    logic [ACC_W-1:0]  w_stp;
    logic              w_up;
    logic              w_on;
    logic              w_stf;
    t_sph              w_sph;

    logic              w_short;
    logic              w_targ_up;
    logic [IDX_W-1:0]  w_diff;
    logic [IDX_W+1:0]  w_diff3;
    logic [mvgif_pkg::DVD_W-1:0] w_dividend;
    logic              w_div_done;
    logic [STEP_W-1:0] w_quot;

    logic [ACC_W-1:0]  w_acc_add;
    logic [ACC_W-1:0]  w_acc_sub;
    logic [IDX_W-1:0]  w_idx_add;
    logic [IDX_W-1:0]  w_idx_sub;

    logic [IDX_W-1:0]  n_cur;
    logic [IDX_W-1:0]  n_tgt;
    logic [ACC_W-1:0]  n_acc;
    logic [STEP_W-1:0] n_stp;
    logic              n_up;
    logic              n_on;
    logic              n_stf;
    t_sph              n_sph;
    logic              n_stop_now;
    logic              w_wr;

    assign w_vidx     = VW'(r_voice);
    assign w_voice_ok = (32'(r_voice) < NUM_VOICES);

    assign w_cur = r_cur[w_vidx];
    assign w_tgt = r_tgt[w_vidx];
    assign w_acc = r_acc[w_vidx];
    assign w_stp = ACC_W'(r_stp[w_vidx]);
    assign w_up  = r_up[w_vidx];
    assign w_on  = r_on[w_vidx];
    assign w_stf = r_stf[w_vidx];
    assign w_sph = r_sph[w_vidx];

    assign w_short    = (r_ms < mvgif_pkg::MS_W'(SHORT_MS));
    assign w_targ_up  = (r_targ > w_cur);
    assign w_diff     = w_targ_up ? (r_targ - w_cur) : (w_cur - r_targ);
    assign w_diff3    = {2'b00, w_diff} + {1'b0, w_diff, 1'b0};
    assign w_dividend = {w_diff3, {FRAC_W{1'b0}}};

    mvgif_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (w_dividend),
        .i_divisor  (r_ms),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_acc_add = w_acc + w_stp;
    assign w_acc_sub = (w_acc >= w_stp) ? (w_acc - w_stp) : '0;
    assign w_idx_add = w_acc_add[FRAC_W +: IDX_W];
    assign w_idx_sub = w_acc_sub[FRAC_W +: IDX_W];

    always_comb begin
        n_cur      = w_cur;
        n_tgt      = w_tgt;
        n_acc      = w_acc;
        n_stp      = r_stp[w_vidx];
        n_up       = w_up;
        n_on       = w_on;
        n_stf      = w_stf;
        n_sph      = w_sph;
        n_stop_now = 1'b0;
        case (t_kind'(r_kind))
            KIND_TICK: begin
                if (w_on) begin
                    if (w_sph == SPH_FINISH) begin
                        n_on       = 1'b0;
                        n_sph      = SPH_NONE;
                        n_stop_now = w_stf;
                    end else if (w_sph != SPH_NONE) begin
                        n_cur = w_tgt;
                        n_sph = SPH_FINISH;
                    end else if (w_up) begin
                        if (w_cur >= w_tgt) begin
                            n_on       = 1'b0;
                            n_stop_now = w_stf;
                        end else begin
                            n_acc = w_acc_add;
                            n_cur = (w_idx_add <= w_tgt) ? w_idx_add : w_tgt;
                        end
                    end else begin
                        if (w_cur <= w_tgt) begin
                            n_on       = 1'b0;
                            n_stop_now = w_stf;
                        end else begin
                            n_acc = w_acc_sub;
                            n_cur = (w_idx_sub >= w_tgt) ? w_idx_sub : w_tgt;
                        end
                    end
                end
            end
            KIND_START: begin
                n_tgt = r_targ;
                if (w_short) begin
                    n_sph = SPH_JUMP;
                    n_stf = r_stop;
                    n_on  = 1'b1;
                end else begin
                    n_sph = SPH_NONE;
                    // a fade to the current index only sets the target and clears the jump phase, starting no fade
                    if (r_targ != w_cur) begin
                        n_up  = w_targ_up;
                        n_stp = w_quot;
                        n_acc = {{(ACC_W-IDX_W-FRAC_W){1'b0}}, w_cur, {FRAC_W{1'b0}}};
                        n_stf = r_stop;
                        n_on  = 1'b1;
                    end
                end
            end
            KIND_STOP: begin
                n_on  = 1'b0;
                n_sph = SPH_NONE;
            end
            KIND_SET: begin
                n_on  = 1'b0;
                n_sph = SPH_NONE;
                n_cur = r_targ;
            end
            default: begin
                n_on = w_on;
            end
        endcase
    end

    assign w_wr = i_cmd.commit && w_voice_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_voice <= i_voice;
            r_targ  <= i_target_index;
            r_ms    <= i_fade_ms;
            r_stop  <= i_stop_at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
                r_acc[i] <= '0;
                r_stp[i] <= '0;
                r_up[i]  <= 1'b0;
                r_on[i]  <= 1'b0;
                r_stf[i] <= 1'b0;
                r_sph[i] <= SPH_NONE;
            end
        end else if (w_wr) begin
            r_cur[w_vidx] <= n_cur;
            r_tgt[w_vidx] <= n_tgt;
            r_acc[w_vidx] <= n_acc;
            r_stp[w_vidx] <= n_stp;
            r_up[w_vidx]  <= n_up;
            r_on[w_vidx]  <= n_on;
            r_stf[w_vidx] <= n_stf;
            r_sph[w_vidx] <= n_sph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // voices past the configured count report a zero gain index and no fading or stop flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_voice  <= r_voice;
            r_out_gain   <= w_voice_ok ? n_cur : '0;
            r_out_fading <= w_voice_ok && n_on;
            r_out_stop   <= w_voice_ok && n_stop_now;
        end
    end

    assign o_sts.need_div = w_voice_ok && (t_kind'(r_kind) == KIND_START) && !w_short
                            && (r_targ != w_cur);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_voice_out  = r_out_voice;
    assign o_gain_index = r_out_gain;
    assign o_fading     = r_out_fading;
    assign o_stop_now   = r_out_stop;

endmodule

`default_nettype wire

/* rtl/core/mvgif_ctrl.sv */
// Controller: sequences accept, divide and commit for one request at a time.
`default_nettype none

module mvgif_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output mvgif_pkg::t_cmd       o_cmd,
    input  wire mvgif_pkg::t_sts  i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= i_sts.need_div ? S_DIV : S_COMMIT;
                end
                S_DIV: begin
                    if (i_sts.div_done) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.start_div = (r_state == S_CHECK) && i_sts.need_div;
    assign o_cmd.commit    = (r_state == S_COMMIT) && i_sts.out_free;

endmodule

`default_nettype wire
